FILE: sv/ols_pkg.sv
// Shared constants and types for the least-squares slope block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package ols_pkg;

  localparam int DATA_W          = 32;
  localparam int BAR_W           = 8;
  localparam int MAX_SAMPLES_DEF = 256;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [BAR_W-1:0] BAR_RESET = 8'd5;

  typedef logic signed [DATA_W-1:0] q16_t;
  typedef logic [BAR_W-1:0]         bar_t;

endpackage

`default_nettype wire

FILE: sv/ols_front.sv
// Front part: accepts samples, skips missing ones, keeps n, sum(y), sum(k*y).
// Pushes one finished series into the job queue per last item. Uses ols_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ols_front #(
  parameter int MAX_SAMPLES = ols_pkg::MAX_SAMPLES_DEF,
  parameter int CW          = $clog2(MAX_SAMPLES + 1),
  parameter int SUMW        = ols_pkg::DATA_W + $clog2(MAX_SAMPLES),
  parameter int KYW         = ols_pkg::DATA_W + 2 * $clog2(MAX_SAMPLES)
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire ols_pkg::q16_t     price,
  input  wire                    missing,
  input  wire                    last,
  output logic                   push,
  input  wire                    queue_full,
  output logic [CW-1:0]          job_n,
  output logic signed [SUMW-1:0] job_sy,
  output logic signed [KYW-1:0]  job_sky
);
  import ols_pkg::*;

  localparam int IW = $clog2(MAX_SAMPLES);

  logic [CW-1:0]             count, count_next;
  logic signed [SUMW-1:0]    sy, sy_next;
  logic signed [KYW-1:0]     sky, sky_next;
  logic signed [IW+DATA_W:0] prod;
  logic                      accept, take;

  always_comb begin
    in_stall = queue_full;
    accept   = in_valid && !in_stall;
    take     = accept && !missing && (count < CW'(MAX_SAMPLES));
    // index of this sample is the count of samples taken so far
    prod       = $signed({1'b0, count[IW-1:0]}) * price;
    count_next = take ? count + CW'(1) : count;
    sy_next    = take ? sy + SUMW'(price) : sy;
    sky_next   = take ? sky + KYW'(prod) : sky;
    push       = accept && last;
    job_n      = count_next;
    job_sy     = sy_next;
    job_sky    = sky_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      sy    <= '0;
      sky   <= '0;
    end else if (push) begin
      // series handed to the back part: start over
      count <= '0;
      sy    <= '0;
      sky   <= '0;
    end else begin
      count <= count_next;
      sy    <= sy_next;
      sky   <= sky_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/ols_queue.sv
// Short job queue between the front and back parts.
// Generic width and depth; the default depth comes from ols_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ols_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = ols_pkg::QUEUE_DEPTH_DEF
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  input  wire [WIDTH-1:0]  push_data,
  input  wire              pop,
  output logic [WIDTH-1:0] head,
  output logic             full,
  output logic             empty
);
  import ols_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [FW-1:0]    fill;

  always_comb begin
    full  = (fill == FW'(DEPTH));
    empty = (fill == '0);
    head  = mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({push && !full, pop && !empty})
        2'b10:   fill <= fill + FW'(1);
        2'b01:   fill <= fill - FW'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/ols_back.sv
// Back part: forms numerator and denominator, runs a one-bit-per-cycle
// rounded divide, saturates and holds the result in the output register.
// Uses ols_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ols_back #(
  parameter int MAX_SAMPLES = ols_pkg::MAX_SAMPLES_DEF,
  parameter int CW          = $clog2(MAX_SAMPLES + 1),
  parameter int SUMW        = ols_pkg::DATA_W + $clog2(MAX_SAMPLES),
  parameter int KYW         = ols_pkg::DATA_W + 2 * $clog2(MAX_SAMPLES)
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire ols_pkg::bar_t     bar_minutes,
  input  wire                    queue_empty,
  output logic                   pop,
  input  wire [CW-1:0]           job_n,
  input  wire signed [SUMW-1:0]  job_sy,
  input  wire signed [KYW-1:0]   job_sky,
  output logic                   out_valid,
  input  wire                    out_stall,
  output ols_pkg::q16_t          slope,
  output logic                   valid_res
);
  import ols_pkg::*;

  localparam int NW  = KYW + 4;
  localparam int PW  = CW + 1 + SUMW;
  localparam int SQW = 2 * CW;
  localparam int DW  = 3 * CW + BAR_W;
  localparam int AW  = NW + 1;
  localparam int KW  = $clog2(AW + 1);

  localparam logic [AW-1:0] POS_MAX = AW'({1'b0, {(DATA_W - 1){1'b1}}});
  localparam logic [AW-1:0] NEG_MAX = AW'({1'b1, {(DATA_W - 1){1'b0}}});

  typedef enum logic [2:0] {
    S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_LOAD, S_DIV, S_FIN
  } state_t;

  state_t                 state;
  logic [CW-1:0]          n_r;
  logic signed [SUMW-1:0] sy_r;
  logic signed [KYW-1:0]  sky_r;
  logic signed [PW-1:0]   p_sy;
  logic [SQW-1:0]         nsq1;
  logic signed [NW-1:0]   num;
  logic [NW-1:0]          mag;
  logic                   neg;
  logic [DW-1:0]          d1, den;
  logic [AW-1:0]          div_a;
  logic [DW-1:0]          rem;
  logic [KW-1:0]          cnt;
  logic                   vld;

  logic [SQW-1:0]         n_sq;
  logic [BAR_W-1:0]       bm_eff;
  logic [DW:0]            trial;
  logic                   ge;
  logic [DATA_W-1:0]      res;

  always_comb begin
    pop    = (state == S_IDLE) && !queue_empty;
    n_sq   = SQW'(n_r);
    bm_eff = (bar_minutes == '0) ? BAR_W'(1) : bar_minutes;
    trial  = {rem, div_a[AW-1]};
    ge     = (trial >= {1'b0, den});
    if (!vld) begin
      res = '0;
    end else if (neg) begin
      res = (div_a > NEG_MAX) ? NEG_MAX[DATA_W-1:0] : DATA_W'(-div_a);
    end else begin
      res = (div_a > POS_MAX) ? POS_MAX[DATA_W-1:0] : div_a[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // drop a taken request unless the next one loads this cycle
      if (out_valid && !out_stall && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!queue_empty) begin
            n_r   <= job_n;
            sy_r  <= job_sy;
            sky_r <= job_sky;
            vld   <= (job_n >= CW'(2));
            state <= (job_n >= CW'(2)) ? S_MUL1 : S_FIN;
          end
        end
        S_MUL1: begin
          p_sy  <= $signed({1'b0, n_r - CW'(1)}) * sy_r;
          nsq1  <= n_sq * n_sq - SQW'(1);
          state <= S_MUL2;
        end
        S_MUL2: begin
          // 12*sum(ky) - 6*(n-1)*sum(y) as shifts and adds
          num   <= (NW'(sky_r) <<< 3) + (NW'(sky_r) <<< 2)
                 - (NW'(p_sy) <<< 2) - (NW'(p_sy) <<< 1);
          d1    <= DW'(n_r) * DW'(nsq1);
          state <= S_MUL3;
        end
        S_MUL3: begin
          den   <= d1 * DW'(bm_eff);
          neg   <= num[NW-1];
          mag   <= num[NW-1] ? NW'(-num) : NW'(num);
          state <= S_LOAD;
        end
        S_LOAD: begin
          // add half the divisor to round to nearest, ties away from zero
          div_a <= AW'(mag) + AW'(den >> 1);
          rem   <= '0;
          cnt   <= KW'(AW);
          state <= S_DIV;
        end
        S_DIV: begin
          rem   <= ge ? DW'(trial - {1'b0, den}) : DW'(trial);
          div_a <= {div_a[AW-2:0], ge};
          cnt   <= cnt - KW'(1);
          if (cnt == KW'(1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          // hold until the output register is free
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            slope     <= res;
            valid_res <= vld;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/ols_slope_skip_missing_core.sv
// Top level of the least-squares slope block: configuration register,
// front accumulator, job queue and back divider. Uses ols_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Computes the least-squares slope of a Q16.16 price series per minute of bar
// length, rounded to nearest and saturated to Q16.16. Missing samples are
// skipped; samples past MAX_SAMPLES are ignored; fewer than two samples give
// slope 0 with valid_res low. The front accumulator takes one sample per
// cycle while the queue is not full (one k*y multiply and two adds). Each
// series marked last enters a two-entry job queue; the back part then loads
// the job, forms numerator and denominator, runs a restoring divide with one
// quotient bit per cycle and loads the output register. A series of fewer
// than two samples skips straight to the output register. The back part
// takes no new job until its last result is loaded. in_stall rises only
// while the queue is full. bar_minutes resets to 5; a value of 0 acts as 1.

module ols_slope_skip_missing_core #(
  parameter int MAX_SAMPLES = ols_pkg::MAX_SAMPLES_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire ols_pkg::q16_t  price,
  input  wire                 missing,
  input  wire                 last,
  output logic                out_valid,
  input  wire                 out_stall,
  output ols_pkg::q16_t       slope,
  output logic                valid_res,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire ols_pkg::bar_t  cfg_data
);
  import ols_pkg::*;

  localparam int CW   = $clog2(MAX_SAMPLES + 1);
  localparam int SUMW = DATA_W + $clog2(MAX_SAMPLES);
  localparam int KYW  = DATA_W + 2 * $clog2(MAX_SAMPLES);
  localparam int JW   = CW + SUMW + KYW;

  bar_t                   bar_minutes;
  logic                   push, pop, queue_full, queue_empty;
  logic [CW-1:0]          f_n, b_n;
  logic signed [SUMW-1:0] f_sy, b_sy;
  logic signed [KYW-1:0]  f_sky, b_sky;
  logic [JW-1:0]          head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bar_minutes <= BAR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      bar_minutes <= cfg_data;
    end
  end

  ols_front #(
    .MAX_SAMPLES(MAX_SAMPLES), .CW(CW), .SUMW(SUMW), .KYW(KYW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .price      (price),
    .missing    (missing),
    .last       (last),
    .push       (push),
    .queue_full (queue_full),
    .job_n      (f_n),
    .job_sy     (f_sy),
    .job_sky    (f_sky)
  );

  ols_queue #(
    .WIDTH(JW), .DEPTH(QUEUE_DEPTH_DEF)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({f_n, f_sy, f_sky}),
    .pop       (pop),
    .head      (head),
    .full      (queue_full),
    .empty     (queue_empty)
  );

  assign b_n   = head[JW-1 -: CW];
  assign b_sy  = head[KYW+SUMW-1 -: SUMW];
  assign b_sky = head[KYW-1:0];

  ols_back #(
    .MAX_SAMPLES(MAX_SAMPLES), .CW(CW), .SUMW(SUMW), .KYW(KYW)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .bar_minutes (bar_minutes),
    .queue_empty (queue_empty),
    .pop         (pop),
    .job_n       (b_n),
    .job_sy      (b_sy),
    .job_sky     (b_sky),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .slope       (slope),
    .valid_res   (valid_res)
  );

endmodule

`default_nettype wire
